/* rtl/core/sphere_through_four_points_top_defines.svh */
// Assertion macros shared by the sphere block.
`ifndef SPHERE_THROUGH_FOUR_POINTS_TOP_DEFINES_SVH
`define SPHERE_THROUGH_FOUR_POINTS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// The expression must hold at every clock edge out of reset.
`define SPTF_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SPTF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPTF_ASSERT_ALWAYS(label, clk, rstn, expr)
`define SPTF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* rtl/core/sptf_pkg.sv */
package sptf_pkg;

    // Field and arithmetic widths.
    localparam int COORD_W  = 16;
    localparam int FRAC     = 8;
    localparam int THR_W    = 56;
    localparam int QB       = 41;   // quotient bits kept by the divider
    localparam int RT       = 34;   // root bits produced by the square root
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;
    localparam int BV_N     = QB + RT + 5;

    // Status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DEGEN = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [16:0] diff_t;
    typedef logic signed [33:0] sq_t;
    typedef logic signed [35:0] ssum_t;
    typedef logic signed [34:0] cof_t;
    typedef logic signed [51:0] dprod_t;
    typedef logic signed [55:0] det_t;
    typedef logic signed [70:0] nprod_t;
    typedef logic signed [71:0] nsum_t;
    typedef logic [54:0] dmag_t;
    typedef logic [70:0] nmag_t;
    typedef logic [THR_W-1:0] thr_t;
    typedef logic [80:0] num_t;
    typedef logic [55:0] den_t;
    typedef logic [96:0] cmp_t;
    typedef logic [QB-1:0] quo_t;
    typedef logic signed [42:0] qs_t;
    typedef logic [31:0] cen_t;
    typedef logic [32:0] qabs_t;
    typedef logic [65:0] qsq_t;
    typedef logic [67:0] rsum_t;
    typedef logic [RT-1:0] root_t;
    typedef logic [69:0] trial_t;
    typedef logic [34:0] rnd_t;

    // One classified item, handed from the front end to the back end.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] p0;
        dmag_t                   dmag;
        logic [2:0][70:0]        nmag;
        logic [2:0]              nneg;
        logic                    degen;
    } item_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic          full;
        logic          empty;
        logic [Q_AW:0] level;
    } q_stat_t;

    // Cyclic neighbors of an index in 0..2.
    function automatic int rot1(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

    function automatic int rot2(input int k);
        return (k == 0) ? 2 : k - 1;
    endfunction

endpackage

/* rtl/core/sptf_front.sv */
module sptf_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [191:0]          s_tdata,
    input  sptf_pkg::thr_t        thr,
    input  logic                  q_full,
    output logic                  q_push,
    output sptf_pkg::item_t       q_item
);

    logic [6:0]             fv_reg;
    logic                   fa;
    sptf_pkg::coord_t       pt_reg [4][3];
    sptf_pkg::coord_t       p0_reg [5][3];
    sptf_pkg::diff_t        d_reg [3][3];
    sptf_pkg::diff_t        d0_s3_reg [3];
    sptf_pkg::diff_t        d0_s4_reg [3];
    sptf_pkg::sq_t          sq_reg [3][3];
    sptf_pkg::sq_t          cpa_reg [3][3];
    sptf_pkg::sq_t          cpb_reg [3][3];
    sptf_pkg::ssum_t        s_reg [3];
    sptf_pkg::cof_t         cof_reg [3][3];
    sptf_pkg::dprod_t       dp_reg [3];
    sptf_pkg::nprod_t       np_reg [3][3];
    sptf_pkg::det_t         det_reg;
    sptf_pkg::nsum_t        n_reg [3];
    sptf_pkg::item_t        item_reg;
    sptf_pkg::item_t        item_next;

    // The whole front end moves as one unless its last stage is blocked.
    assign fa       = !fv_reg[6] || !q_full;
    assign s_tready = fa;
    assign q_push   = fv_reg[6] && !q_full;
    assign q_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (fa) begin
            fv_reg <= {fv_reg[5:0], s_tvalid && fa};
        end
    end

    // Magnitudes, signs and the degeneracy test of the last stage.
    always_comb begin
        item_next.p0 = {p0_reg[4][2], p0_reg[4][1], p0_reg[4][0]};
        item_next.dmag = sptf_pkg::dmag_t'(det_reg[55] ? -det_reg : det_reg);
        for (int i = 0; i < 3; i++) begin
            item_next.nneg[i] = n_reg[i][71];
            item_next.nmag[i] = sptf_pkg::nmag_t'(n_reg[i][71] ? -n_reg[i] : n_reg[i]);
        end
        item_next.degen = (item_next.dmag == '0) ||
                          ({item_next.dmag, 3'b000} < {2'b00, thr});
    end

    // Arithmetic stages: differences, products, cofactors, sums.
    always_ff @(posedge aclk) begin
        if (fa) begin
            for (int k = 0; k < 4; k++) begin
                for (int i = 0; i < 3; i++) begin
                    pt_reg[k][i] <= s_tdata[(3 * k + i) * sptf_pkg::COORD_W +: sptf_pkg::COORD_W];
                end
            end
            for (int i = 0; i < 3; i++) begin
                p0_reg[0][i] <= pt_reg[0][i];
                for (int j = 1; j < 5; j++) begin
                    p0_reg[j][i] <= p0_reg[j - 1][i];
                end
            end
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    d_reg[k][i] <= sptf_pkg::diff_t'(pt_reg[k + 1][i])
                                 - sptf_pkg::diff_t'(pt_reg[0][i]);
                    sq_reg[k][i] <= d_reg[k][i] * d_reg[k][i];
                    cpa_reg[k][i] <= d_reg[sptf_pkg::rot1(k)][sptf_pkg::rot1(i)]
                                   * d_reg[sptf_pkg::rot2(k)][sptf_pkg::rot2(i)];
                    cpb_reg[k][i] <= d_reg[sptf_pkg::rot1(k)][sptf_pkg::rot2(i)]
                                   * d_reg[sptf_pkg::rot2(k)][sptf_pkg::rot1(i)];
                    cof_reg[k][i] <= sptf_pkg::cof_t'(cpa_reg[k][i])
                                   - sptf_pkg::cof_t'(cpb_reg[k][i]);
                    np_reg[k][i] <= sptf_pkg::nprod_t'(cof_reg[k][i])
                                  * sptf_pkg::nprod_t'(s_reg[k]);
                end
                s_reg[k] <= sptf_pkg::ssum_t'(sq_reg[k][0]) + sptf_pkg::ssum_t'(sq_reg[k][1])
                          + sptf_pkg::ssum_t'(sq_reg[k][2]);
            end
            for (int i = 0; i < 3; i++) begin
                d0_s3_reg[i] <= d_reg[0][i];
                d0_s4_reg[i] <= d0_s3_reg[i];
                dp_reg[i] <= sptf_pkg::dprod_t'(d0_s4_reg[i])
                           * sptf_pkg::dprod_t'(cof_reg[0][i]);
                n_reg[i] <= sptf_pkg::nsum_t'(np_reg[0][i]) + sptf_pkg::nsum_t'(np_reg[1][i])
                          + sptf_pkg::nsum_t'(np_reg[2][i]);
            end
            det_reg <= sptf_pkg::det_t'(dp_reg[0]) + sptf_pkg::det_t'(dp_reg[1])
                     + sptf_pkg::det_t'(dp_reg[2]);
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/core/sptf_queue.sv */
module sptf_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  sptf_pkg::item_t       wr_item,
    input  logic                  pop,
    output sptf_pkg::item_t       rd_item,
    output sptf_pkg::q_stat_t     stat
);

    sptf_pkg::item_t             mem_reg [sptf_pkg::Q_DEPTH];
    logic [sptf_pkg::Q_AW-1:0]   wr_ptr_reg;
    logic [sptf_pkg::Q_AW-1:0]   rd_ptr_reg;
    logic [sptf_pkg::Q_AW:0]     level_reg;

    assign rd_item    = mem_reg[rd_ptr_reg];
    assign stat.level = level_reg;
    assign stat.full  = level_reg == (sptf_pkg::Q_AW + 1)'(sptf_pkg::Q_DEPTH);
    assign stat.empty = level_reg == '0;

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

/* rtl/core/sptf_back.sv */
module sptf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sptf_pkg::item_t       q_item,
    input  sptf_pkg::q_stat_t     q_stat,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [127:0]          m_tdata,
    output logic [1:0]            m_tuser
);

    logic                      be;
    logic [sptf_pkg::BV_N-1:0] bv_reg;

    // Entry stage.
    sptf_pkg::num_t            b0_num_reg [3];
    sptf_pkg::den_t            b0_den_reg;
    logic [2:0]                b0_neg_reg;
    logic                      b0_degen_reg;
    sptf_pkg::coord_t          b0_p0_reg [3];

    // Divider stages.
    sptf_pkg::num_t            rem_reg [sptf_pkg::QB][3];
    sptf_pkg::quo_t            quo_reg [sptf_pkg::QB][3];
    logic                      ovf_reg [sptf_pkg::QB][3];
    sptf_pkg::den_t            den_reg [sptf_pkg::QB];
    logic [2:0]                dneg_reg [sptf_pkg::QB];
    logic                      ddeg_reg [sptf_pkg::QB];
    sptf_pkg::coord_t          dp0_reg [sptf_pkg::QB][3];
    sptf_pkg::num_t            div_rem_in [sptf_pkg::QB][3];
    sptf_pkg::quo_t            div_quo_in [sptf_pkg::QB][3];
    sptf_pkg::den_t            div_den_in [sptf_pkg::QB];
    sptf_pkg::cmp_t            div_trial [sptf_pkg::QB];

    // Centre, squares and sum.
    sptf_pkg::qs_t             e1_cen [3];
    sptf_pkg::qs_t             e1_q [3];
    logic                      e1_sat;
    sptf_pkg::cen_t            cen_reg [3];
    sptf_pkg::qabs_t           qabs_reg [3];
    logic                      e_sat_reg [3];
    logic                      e_deg_reg [3];
    sptf_pkg::cen_t            cen2_reg [3];
    sptf_pkg::cen_t            cen3_reg [3];
    sptf_pkg::qsq_t            qsq_reg [3];
    sptf_pkg::rsum_t           rsum_reg;

    // Square root stages.
    sptf_pkg::rsum_t           srem_reg [sptf_pkg::RT];
    sptf_pkg::root_t           sroot_reg [sptf_pkg::RT];
    logic                      ssat_reg [sptf_pkg::RT];
    logic                      sdeg_reg [sptf_pkg::RT];
    sptf_pkg::cen_t            scen_reg [sptf_pkg::RT][3];
    sptf_pkg::rsum_t           sq_rem_in [sptf_pkg::RT];
    sptf_pkg::root_t           sq_root_in [sptf_pkg::RT];
    sptf_pkg::trial_t          sq_trial [sptf_pkg::RT];

    // Output.
    sptf_pkg::rnd_t            rnd;
    logic                      fin_sat;
    logic [1:0]                fin_status;
    logic [127:0]              data_reg;
    logic [1:0]                status_reg;

    assign be       = !bv_reg[sptf_pkg::BV_N-1] || m_tready;
    assign q_pop    = be && !q_stat.empty;
    assign m_tvalid = bv_reg[sptf_pkg::BV_N-1];
    assign m_tdata  = data_reg;
    assign m_tuser  = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= '0;
        end else if (be) begin
            bv_reg <= {bv_reg[sptf_pkg::BV_N-2:0], q_pop};
        end
    end

    // Stage inputs and trial values of the divider and the square root.
    always_comb begin
        for (int j = 0; j < sptf_pkg::QB; j++) begin
            div_den_in[j] = (j == 0) ? b0_den_reg : den_reg[j - 1];
            div_trial[j] = sptf_pkg::cmp_t'(div_den_in[j]) << (sptf_pkg::QB - 1 - j);
            for (int i = 0; i < 3; i++) begin
                div_rem_in[j][i] = (j == 0) ? b0_num_reg[i] : rem_reg[j - 1][i];
                div_quo_in[j][i] = (j == 0) ? '0 : quo_reg[j - 1][i];
            end
        end
        for (int j = 0; j < sptf_pkg::RT; j++) begin
            sq_rem_in[j]  = (j == 0) ? rsum_reg : srem_reg[j - 1];
            sq_root_in[j] = (j == 0) ? '0 : sroot_reg[j - 1];
            sq_trial[j] = (sptf_pkg::trial_t'(sq_root_in[j]) << (sptf_pkg::RT - j))
                        + (sptf_pkg::trial_t'(1) << (2 * (sptf_pkg::RT - 1 - j)));
        end
    end

    // Signed centre and its range check after the last quotient bit.
    always_comb begin
        e1_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            e1_q[i] = dneg_reg[sptf_pkg::QB - 1][i]
                    ? -sptf_pkg::qs_t'(quo_reg[sptf_pkg::QB - 1][i])
                    : sptf_pkg::qs_t'(quo_reg[sptf_pkg::QB - 1][i]);
            e1_cen[i] = (sptf_pkg::qs_t'(dp0_reg[sptf_pkg::QB - 1][i]) <<< sptf_pkg::FRAC)
                      + e1_q[i];
            if (ovf_reg[sptf_pkg::QB - 1][i]
                || (quo_reg[sptf_pkg::QB - 1][i][sptf_pkg::QB - 1]
                    && (quo_reg[sptf_pkg::QB - 1][i][sptf_pkg::QB - 2:0] != '0))
                || !((e1_cen[i][42:31] == '0) || (e1_cen[i][42:31] == '1))) begin
                e1_sat = 1'b1;
            end
        end
    end

    // Rounding of the root and the final status.
    always_comb begin
        rnd = sptf_pkg::rnd_t'(sroot_reg[sptf_pkg::RT - 1])
            + sptf_pkg::rnd_t'(srem_reg[sptf_pkg::RT - 1]
                               > sptf_pkg::rsum_t'(sroot_reg[sptf_pkg::RT - 1]));
        fin_sat = ssat_reg[sptf_pkg::RT - 1] || (rnd[34:32] != '0);
        if (sdeg_reg[sptf_pkg::RT - 1]) begin
            fin_status = sptf_pkg::STAT_DEGEN;
        end else if (fin_sat) begin
            fin_status = sptf_pkg::STAT_SAT;
        end else begin
            fin_status = sptf_pkg::STAT_OK;
        end
    end

    // Datapath registers, all moving on the back-end enable.
    always_ff @(posedge aclk) begin
        if (be) begin
            // Scaled numerator with half the divisor added for rounding.
            for (int i = 0; i < 3; i++) begin
                b0_num_reg[i] <= (sptf_pkg::num_t'(q_item.nmag[i]) << sptf_pkg::FRAC)
                               + sptf_pkg::num_t'(q_item.dmag);
                b0_p0_reg[i] <= q_item.p0[i];
            end
            b0_den_reg   <= {q_item.dmag, 1'b0};
            b0_neg_reg   <= q_item.nneg;
            b0_degen_reg <= q_item.degen;

            // One quotient bit per stage, most significant first.
            for (int j = 0; j < sptf_pkg::QB; j++) begin
                den_reg[j]  <= div_den_in[j];
                dneg_reg[j] <= (j == 0) ? b0_neg_reg : dneg_reg[j - 1];
                ddeg_reg[j] <= (j == 0) ? b0_degen_reg : ddeg_reg[j - 1];
                for (int i = 0; i < 3; i++) begin
                    dp0_reg[j][i] <= (j == 0) ? b0_p0_reg[i] : dp0_reg[j - 1][i];
                    ovf_reg[j][i] <= (j == 0)
                        ? (sptf_pkg::cmp_t'(b0_num_reg[i])
                           >= (sptf_pkg::cmp_t'(b0_den_reg) << sptf_pkg::QB))
                        : ovf_reg[j - 1][i];
                    if (sptf_pkg::cmp_t'(div_rem_in[j][i]) >= div_trial[j]) begin
                        rem_reg[j][i] <= div_rem_in[j][i] - sptf_pkg::num_t'(div_trial[j]);
                        quo_reg[j][i] <= div_quo_in[j][i]
                                       | (sptf_pkg::quo_t'(1) << (sptf_pkg::QB - 1 - j));
                    end else begin
                        rem_reg[j][i] <= div_rem_in[j][i];
                        quo_reg[j][i] <= div_quo_in[j][i];
                    end
                end
            end

            // Centre, squared offsets, their sum.
            for (int i = 0; i < 3; i++) begin
                cen_reg[i]  <= e1_cen[i][31:0];
                qabs_reg[i] <= quo_reg[sptf_pkg::QB - 1][i][32:0];
                cen2_reg[i] <= cen_reg[i];
                cen3_reg[i] <= cen2_reg[i];
                qsq_reg[i]  <= sptf_pkg::qsq_t'(qabs_reg[i]) * sptf_pkg::qsq_t'(qabs_reg[i]);
            end
            e_sat_reg[0] <= e1_sat;
            e_sat_reg[1] <= e_sat_reg[0];
            e_sat_reg[2] <= e_sat_reg[1];
            e_deg_reg[0] <= ddeg_reg[sptf_pkg::QB - 1];
            e_deg_reg[1] <= e_deg_reg[0];
            e_deg_reg[2] <= e_deg_reg[1];
            rsum_reg <= sptf_pkg::rsum_t'(qsq_reg[0]) + sptf_pkg::rsum_t'(qsq_reg[1])
                      + sptf_pkg::rsum_t'(qsq_reg[2]);

            // One root bit per stage, most significant first.
            for (int j = 0; j < sptf_pkg::RT; j++) begin
                ssat_reg[j] <= (j == 0) ? e_sat_reg[2] : ssat_reg[j - 1];
                sdeg_reg[j] <= (j == 0) ? e_deg_reg[2] : sdeg_reg[j - 1];
                for (int i = 0; i < 3; i++) begin
                    scen_reg[j][i] <= (j == 0) ? cen3_reg[i] : scen_reg[j - 1][i];
                end
                if (sptf_pkg::trial_t'(sq_rem_in[j]) >= sq_trial[j]) begin
                    srem_reg[j]  <= sq_rem_in[j] - sptf_pkg::rsum_t'(sq_trial[j]);
                    sroot_reg[j] <= sq_root_in[j]
                                  | (sptf_pkg::root_t'(1) << (sptf_pkg::RT - 1 - j));
                end else begin
                    srem_reg[j]  <= sq_rem_in[j];
                    sroot_reg[j] <= sq_root_in[j];
                end
            end

            // Output register; failed items carry zeros.
            status_reg <= fin_status;
            if (fin_status == sptf_pkg::STAT_OK) begin
                data_reg <= {rnd[31:0], scen_reg[sptf_pkg::RT - 1][2],
                             scen_reg[sptf_pkg::RT - 1][1], scen_reg[sptf_pkg::RT - 1][0]};
            end else begin
                data_reg <= '0;
            end
        end
    end

endmodule

/* rtl/core/sphere_through_four_points_top.sv */
// Sphere through four points.
// Input channel s_*: one transaction carries four points p0..p3, each as signed
// 16-bit x, y, z. Result channel m_*: centre and radius with 8 extra fraction
// bits, plus a status code (success, degenerate points, saturated result).
// Configuration channel cfg_*: writes the 56-bit determinant threshold; it is
// always ready and should only be written while the block is idle.
// Throughput is one transaction per cycle while the output is not stalled.
// From input to result the path runs through the input register, 6 front stages
// for differences, cofactors and the determinant, the queue, an entry stage
// that scales the numerator, a pipelined restoring divider (41 stages, one
// quotient bit each), three stages for centre and squared offsets, a 34-stage
// square root and the output register.
// A stalled receiver freezes the back pipeline; the front keeps taking input
// until the 4-entry queue fills, then drops s_tready.
// Reset (aresetn low, synchronous) empties all stages and the queue and sets
// the threshold to 1.
`include "sphere_through_four_points_top_defines.svh"

module sphere_through_four_points_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
    input  logic [191:0]   s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // centre_x, centre_y, centre_z, sphere_radius
    output logic [127:0]   m_tdata,
    // status
    output logic [1:0]     m_tuser,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [55:0]    cfg_data
);

    sptf_pkg::thr_t        thr_reg;
    sptf_pkg::item_t       push_item;
    sptf_pkg::item_t       pop_item;
    sptf_pkg::q_stat_t     q_stat;
    logic                  q_push;
    logic                  q_pop;

    // Threshold register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= sptf_pkg::thr_t'(1);
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    sptf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .thr      (thr_reg),
        .q_full   (q_stat.full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    sptf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_item  (push_item),
        .pop      (q_pop),
        .rd_item  (pop_item),
        .stat     (q_stat)
    );

    sptf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (pop_item),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The queue is never written while full nor read while empty.
    `SPTF_ASSERT_ALWAYS(a_queue_bounds, aclk, aresetn, !(q_push && q_stat.full) && !(q_pop && q_stat.empty))
    // A failed result carries all-zero data.
    `SPTF_ASSERT_ALWAYS(a_fail_zero, aclk, aresetn, !(m_tvalid && (m_tuser != sptf_pkg::STAT_OK) && (m_tdata != '0)))
    // Only defined status codes leave the block.
    `SPTF_ASSERT_ALWAYS(a_status_code, aclk, aresetn, !m_tvalid || (m_tuser == sptf_pkg::STAT_OK) || (m_tuser == sptf_pkg::STAT_DEGEN) || (m_tuser == sptf_pkg::STAT_SAT))
    // A push without a pop leaves the queue non-empty in the next cycle.
    `SPTF_ASSERT_NEXT(a_queue_fill, aclk, aresetn, q_push && !q_pop, !q_stat.empty)

endmodule
